/* design/first_fit_bar_cutting_macros.svh */
// Assertion macros for the bar cutting checker.
`ifndef FIRST_FIT_BAR_CUTTING_MACROS_SVH
`define FIRST_FIT_BAR_CUTTING_MACROS_SVH

// Assert a property on a given clock, off while the active-low reset is low.
`define FBC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assert a property on the default clock and reset of the checker.
`define FBC_ASSERT(lbl, prop, msg) `FBC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* design/fbc_pkg.sv */
// Types and constants of the first-fit bar cutting block.
package fbc_pkg;

  localparam int REQ_W      = 2;
  localparam int FLD_LEN_W  = 16;
  localparam int TAG_W      = 16;
  localparam int KIND_W     = 3;
  localparam int CNT_OUT_W  = 6;
  localparam int KERF_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_CUT    = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_ACK    = 3'd0,
    KIND_CUT_PIECE   = 3'd1,
    KIND_BAR_SUM     = 3'd2,
    KIND_UNCUT_PIECE = 3'd3,
    KIND_UNCUT_SUM   = 3'd4
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] CFG_KERF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SORT = 2'd1;

  typedef struct packed {
    logic [KERF_W-1:0] kerf;
    logic              sort_on_load;
  } cfg_t;

  typedef struct packed {
    kind_e                kind;
    logic [TAG_W-1:0]     piece_tag;
    logic [FLD_LEN_W-1:0] piece_length;
    logic [FLD_LEN_W-1:0] remainder;
    logic [CNT_OUT_W-1:0] piece_count;
    logic                 status;
    logic                 last;
  } result_t;

endpackage

/* design/fbc_ifs.sv */
// Channel interfaces of the bar cutting block: request, result and configuration.
interface fbc_req_if;
  import fbc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [FLD_LEN_W-1:0] length_value;
  logic [TAG_W-1:0]     part_tag;
  modport source (output valid, req_type, length_value, part_tag, input ready);
  modport sink (input valid, req_type, length_value, part_tag, output ready);
endinterface

interface fbc_res_if;
  import fbc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [TAG_W-1:0]     piece_tag;
  logic [FLD_LEN_W-1:0] piece_length;
  logic [FLD_LEN_W-1:0] remainder;
  logic [CNT_OUT_W-1:0] piece_count;
  logic                 status;
  logic                 last;
  modport source (output valid, kind, piece_tag, piece_length, remainder, piece_count,
                  status, last, input ready);
  modport sink (input valid, kind, piece_tag, piece_length, remainder, piece_count,
                status, last, output ready);
endinterface

interface fbc_cfg_if;
  import fbc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/fbc_mem.sv */
// Part table memory: one write port, one read port, registered read data.
module fbc_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read so a stalled walk keeps its entry.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fbc_seq.sv */
// Sequencer: walks the part table for inserts, cuts and reports.
module fbc_seq #(
  parameter int MAX_PARTS = 32,
  parameter int LEN_BITS  = 16
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  fbc_pkg::cfg_t                                  cfg_i,
  input  logic                                           req_valid_i,
  output logic                                           req_ready_o,
  input  logic [fbc_pkg::REQ_W-1:0]                      req_type_i,
  input  logic [fbc_pkg::FLD_LEN_W-1:0]                  len_i,
  input  logic [fbc_pkg::TAG_W-1:0]                      tag_i,
  output logic                                           emit_valid_o,
  output fbc_pkg::result_t                               emit_o,
  input  logic                                           emit_ready_i,
  output logic                                           mem_we_o,
  output logic [$clog2(MAX_PARTS)-1:0]                   mem_waddr_o,
  output logic [fbc_pkg::TAG_W+LEN_BITS:0]               mem_wdata_o,
  output logic                                           mem_re_o,
  output logic [$clog2(MAX_PARTS)-1:0]                   mem_raddr_o,
  input  logic [fbc_pkg::TAG_W+LEN_BITS:0]               mem_rdata_i
);
  import fbc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_PARTS);
  localparam int CNT_W  = $clog2(MAX_PARTS + 1);
  localparam int ENT_W  = 1 + TAG_W + LEN_BITS;
  localparam int NEED_W = ((LEN_BITS > KERF_W) ? LEN_BITS : KERF_W) + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INS  = 3'd1;
  localparam logic [2:0] ST_PUT  = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;

  logic [2:0]          state_q, state_d;
  req_type_e           req_q, req_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic [TAG_W-1:0]    tag_q, tag_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                full_q, full_d;
  logic [ENT_W-1:0]    carry_q, carry_d;
  logic                shift_q, shift_d;

  logic                rd_pend;
  logic [TAG_W-1:0]    rd_tag;
  logic [LEN_BITS-1:0] rd_len;
  logic [NEED_W-1:0]   need;
  logic                fits;
  logic                take;
  logic                last_idx;
  logic [ENT_W-1:0]    new_ent;

  assign rd_pend  = mem_rdata_i[ENT_W-1];
  assign rd_tag   = mem_rdata_i[LEN_BITS +: TAG_W];
  assign rd_len   = mem_rdata_i[LEN_BITS-1:0];
  assign need     = NEED_W'(rd_len) + NEED_W'(cfg_i.kerf);
  assign fits     = NEED_W'(len_q) > need;
  assign take     = rd_pend && ((req_q == REQ_CUT) ? fits : 1'b1);
  assign last_idx = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
  assign new_ent  = {1'b1, tag_q, len_q};

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    len_d        = len_q;
    tag_d        = tag_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    count_d      = count_q;
    full_d       = full_q;
    carry_d      = carry_q;
    shift_d      = shift_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wdata_o  = new_ent;
    mem_re_o     = 1'b0;
    mem_raddr_o  = '0;
    emit_valid_o = 1'b0;
    emit_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d  = req_type_e'(req_type_i);
          len_d  = LEN_BITS'(len_i);
          tag_d  = tag_i;
          idx_d  = '0;
          cnt_d  = '0;
          full_d = 1'b0;
          unique case (req_type_e'(req_type_i))
            REQ_LOAD: begin
              if (count_q >= CNT_W'(MAX_PARTS)) begin
                full_d  = 1'b1;
                state_d = ST_SUM;
              end else if (!cfg_i.sort_on_load || count_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = IDX_W'(count_q);
                mem_wdata_o = {1'b1, tag_i, LEN_BITS'(len_i)};
                count_d     = count_q + CNT_W'(1);
                state_d     = ST_SUM;
              end else begin
                mem_re_o = 1'b1;
                carry_d  = {1'b1, tag_i, LEN_BITS'(len_i)};
                shift_d  = 1'b0;
                state_d  = ST_INS;
              end
            end
            REQ_CUT, REQ_REPORT: begin
              if (count_q == '0) begin
                state_d = ST_SUM;
              end else begin
                mem_re_o = 1'b1;
                state_d  = ST_WALK;
              end
            end
            REQ_CLEAR: begin
              count_d = '0;
            end
          endcase
        end
      end
      ST_INS: begin
        // Walk from the bottom up; from the first longer entry on, drop the
        // carried entry into the slot and carry the old one up a slot.
        if (shift_q || rd_len > len_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_q;
          mem_wdata_o = carry_q;
          carry_d     = mem_rdata_i;
          shift_d     = 1'b1;
        end
        if (last_idx) begin
          state_d = ST_PUT;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + IDX_W'(1);
          idx_d       = idx_q + IDX_W'(1);
        end
      end
      ST_PUT: begin
        // Place the carried entry in the first free slot.
        mem_we_o    = 1'b1;
        mem_waddr_o = IDX_W'(count_q);
        mem_wdata_o = carry_q;
        count_d     = count_q + CNT_W'(1);
        state_d     = ST_SUM;
      end
      ST_WALK: begin
        // Hold the entry while a piece cannot leave.
        if (!take || emit_ready_i) begin
          if (take) begin
            emit_valid_o        = 1'b1;
            emit_o.kind         = (req_q == REQ_CUT) ? KIND_CUT_PIECE : KIND_UNCUT_PIECE;
            emit_o.piece_tag    = rd_tag;
            emit_o.piece_length = FLD_LEN_W'(rd_len);
            cnt_d               = cnt_q + CNT_W'(1);
            if (req_q == REQ_CUT) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = idx_q;
              mem_wdata_o = {1'b0, rd_tag, rd_len};
              len_d       = LEN_BITS'(NEED_W'(len_q) - need);
            end
          end
          if (last_idx) begin
            state_d = ST_SUM;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_q + IDX_W'(1);
            idx_d       = idx_q + IDX_W'(1);
          end
        end
      end
      ST_SUM: begin
        if (emit_ready_i) begin
          emit_valid_o = 1'b1;
          emit_o.last  = 1'b1;
          unique case (req_q)
            REQ_LOAD: begin
              emit_o.kind         = KIND_LOAD_ACK;
              emit_o.piece_tag    = tag_q;
              emit_o.piece_length = FLD_LEN_W'(len_q);
              emit_o.piece_count  = CNT_OUT_W'(count_q);
              emit_o.status       = full_q;
            end
            REQ_CUT: begin
              emit_o.kind        = KIND_BAR_SUM;
              emit_o.remainder   = FLD_LEN_W'(len_q);
              emit_o.piece_count = CNT_OUT_W'(cnt_q);
            end
            REQ_REPORT: begin
              emit_o.kind        = KIND_UNCUT_SUM;
              emit_o.piece_count = CNT_OUT_W'(cnt_q);
            end
            REQ_CLEAR: begin
              emit_valid_o = 1'b0;
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    len_q   <= len_d;
    tag_q   <= tag_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    full_q  <= full_d;
    carry_q <= carry_d;
    shift_q <= shift_d;
  end

endmodule

/* design/first_fit_bar_cutting.sv */
// Top level of the first-fit bar cutting block.
//
//   channel  dir  modport  carries
//   req_i    in   sink     req_type, length_value, part_tag
//   res_o    out  source   kind, piece_tag, piece_length, remainder, piece_count,
//                          status, last
//   cfg_i    in   sink     index (0 kerf, 1 sort_on_load), data
//
// A load that appends writes and acknowledges; an ordered insert walks the table,
// places the carried entry and acknowledges; a cut or report walks, then sums. The
// walk advances one entry per cycle, set by the single read port, unless it stalls.
// Reset idles the sequencer, clears the part count, sets kerf 0 and sort_on_load on; the table
// memory needs no clearing pass since only entries below the count are read.
// A stalled result holds the walk at its current entry; requests are taken only
// between runs, while a finished result may still wait in the output register.
module first_fit_bar_cutting #(
  parameter int MAX_PARTS = 32,
  parameter int LEN_BITS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fbc_req_if.sink  req_i,
  fbc_res_if.source res_o,
  fbc_cfg_if.sink  cfg_i
);
  import fbc_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTS);
  localparam int ENT_W = 1 + TAG_W + LEN_BITS;

  logic [KERF_W-1:0] kerf_q;
  logic              sort_q;
  cfg_t              cfg;

  logic              emit_valid;
  result_t           emit;
  logic              emit_ready;

  logic              res_valid_q;
  result_t           res_q;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;

  // Configuration: always ready, write the addressed register, drop others.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kerf_q <= '0;
      sort_q <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_KERF: begin
          kerf_q <= cfg_i.data[KERF_W-1:0];
        end
        CFG_SORT: begin
          sort_q <= cfg_i.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.kerf         = kerf_q;
  assign cfg.sort_on_load = sort_q;

  // Output register: load a new result when empty or when the held one leaves.
  assign emit_ready = !res_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (emit_valid) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid) begin
      res_q <= emit;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.piece_tag    = res_q.piece_tag;
  assign res_o.piece_length = res_q.piece_length;
  assign res_o.remainder    = res_q.remainder;
  assign res_o.piece_count  = res_q.piece_count;
  assign res_o.status       = res_q.status;
  assign res_o.last         = res_q.last;

  fbc_seq #(
    .MAX_PARTS (MAX_PARTS),
    .LEN_BITS  (LEN_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_type_i   (req_i.req_type),
    .len_i        (req_i.length_value),
    .tag_i        (req_i.part_tag),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .emit_ready_i (emit_ready),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Part table entry: pending flag, tag, length.
  fbc_mem #(
    .DEPTH (MAX_PARTS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* design/fbc_checker.sv */
// Port checker for the bar cutting block, bound to the top level.
`include "first_fit_bar_cutting_macros.svh"

module fbc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic [fbc_pkg::REQ_W-1:0]      req_type_i,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [fbc_pkg::KIND_W-1:0]     kind_i,
  input logic [fbc_pkg::TAG_W-1:0]      piece_tag_i,
  input logic [fbc_pkg::FLD_LEN_W-1:0]  piece_length_i,
  input logic [fbc_pkg::FLD_LEN_W-1:0]  remainder_i,
  input logic [fbc_pkg::CNT_OUT_W-1:0]  piece_count_i,
  input logic                           status_i,
  input logic                           last_i
);
  import fbc_pkg::*;

  localparam int RES_W = KIND_W + TAG_W + 2 * FLD_LEN_W + CNT_OUT_W + 2;

  logic [RES_W-1:0] res_bits;
  logic             req_fire;
  logic             is_summary;

  assign res_bits   = {kind_i, piece_tag_i, piece_length_i, remainder_i, piece_count_i,
                       status_i, last_i};
  assign req_fire   = req_valid_i && req_ready_i;
  assign is_summary = (kind_i == KIND_LOAD_ACK) || (kind_i == KIND_BAR_SUM) ||
                      (kind_i == KIND_UNCUT_SUM);

  `FBC_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_bits), "stalled result changed")
  `FBC_ASSERT(a_busy_after_req, req_fire && req_type_i != REQ_CLEAR |=> !req_ready_i, "request taken in a run")
  `FBC_ASSERT(a_last_on_summary, res_valid_i |-> (last_i == is_summary), "last flag does not match kind")
  `FBC_ASSERT(a_piece_in_run, res_valid_i && !last_i |-> !req_ready_i, "per-part result outside a run")

endmodule

bind first_fit_bar_cutting fbc_checker u_fbc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_type_i     (req_i.req_type),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .kind_i         (res_o.kind),
  .piece_tag_i    (res_o.piece_tag),
  .piece_length_i (res_o.piece_length),
  .remainder_i    (res_o.remainder),
  .piece_count_i  (res_o.piece_count),
  .status_i       (res_o.status),
  .last_i         (res_o.last)
);
